// ===== rtl/sensor_pair_period_with_staged_start_core_macros.svh =====
// Assertion macros shared by the checker of the sensor pair period core.
`ifndef SENSOR_PAIR_PERIOD_WITH_STAGED_START_CORE_MACROS_SVH
`define SENSOR_PAIR_PERIOD_WITH_STAGED_START_CORE_MACROS_SVH

// Checks a property at every rising clock edge outside of reset.
`define SPP_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checks that a condition at one edge implies a consequence at the same edge.
`define SPP_ASSERT_IMPLIES(label, clk, rst_n, cond, cons, msg) \
    `SPP_ASSERT(label, clk, rst_n, (cond) |-> (cons), msg)

`endif

// ===== rtl/spp_pkg.sv =====
// Package with the types and constants of the sensor pair period core.
package spp_pkg;

    localparam int FIRST_EDGES_W  = 4;
    localparam int SECOND_EDGES_W = 6;
    localparam int SENSOR_W       = 8;
    localparam int TIMER_W        = 16;
    localparam int COUNT_W        = 32;
    localparam int SPEED_W        = 16;

    localparam logic [0:0] CFG_IDX_FIRST_STAGE_SPEED  = 1'b0;
    localparam logic [0:0] CFG_IDX_SECOND_STAGE_SPEED = 1'b1;

    localparam logic OP_SENSOR_EDGE    = 1'b0;
    localparam logic OP_OVERFLOW_TICK  = 1'b1;

    localparam logic [SENSOR_W-1:0] SENSOR_NONE  = 8'd0;
    localparam logic [SENSOR_W-1:0] SENSOR_FIRST = 8'd1;

    localparam logic [COUNT_W-1:0] FEED_FACTOR = 32'd50;

    typedef struct packed {
        logic                operation;
        logic [SENSOR_W-1:0] sensor_id;
        logic [TIMER_W-1:0]  timer_value;
        logic                maintenance_mode;
    } t_in_item;

    typedef struct packed {
        logic               period_valid;
        logic [COUNT_W-1:0] period_count;
        logic               control_feed_valid;
        logic [COUNT_W-1:0] control_feed;
        logic               start_speed_write;
        logic [SPEED_W-1:0] start_speed;
        logic               loop_enabled;
    } t_out_item;

    typedef struct packed {
        logic               period_valid;
        logic [COUNT_W-1:0] period_count;
        logic               feed_valid;
        logic               start_speed_write;
        logic [SPEED_W-1:0] start_speed;
        logic               loop_enabled;
    } t_stage_item;

endpackage

// ===== rtl/spp_if.sv =====
// Valid/ready channel interfaces for the input events and the results.
interface spp_in_if;
    logic              valid;
    logic              ready;
    spp_pkg::t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface spp_out_if;
    logic               valid;
    logic               ready;
    spp_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/sensor_pair_period_with_staged_start_core.sv =====
// Top level of the sensor pair period meter with its two-stage start sequence.
//
// The core takes one event transaction each cycle unless the output stalls and returns exactly
// one result per event, in order, via the stage and output registers. The first stage updates
// tracking, the overflow count and the start sequence and forms the period; the second stage
// scales the period by 50 for the speed controller into the output register. A stalled output
// holds both stages; input ready falls only when both are full. The user writes start speeds
// on the configuration port only with no transaction in flight; the core does not enforce it.
module sensor_pair_period_with_staged_start_core #(
    parameter int FIRST_STAGE_EDGES  = 12,
    parameter int SECOND_STAGE_EDGES = 60
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [0:0]                    i_cfg_idx,
    input  logic [spp_pkg::SPEED_W-1:0]   i_cfg_data,
    spp_in_if.sink                        i_in,
    spp_out_if.source                     o_out
);

    logic [spp_pkg::SPEED_W-1:0]        r_first_speed;
    logic [spp_pkg::SPEED_W-1:0]        r_second_speed;

    logic [spp_pkg::SENSOR_W-1:0]       r_last_sensor,  n_last_sensor;
    logic [spp_pkg::TIMER_W-1:0]        r_last_timer,   n_last_timer;
    logic [spp_pkg::COUNT_W-1:0]        r_overflow,     n_overflow;
    logic                               r_stage,        n_stage;
    logic [spp_pkg::FIRST_EDGES_W-1:0]  r_first_edges,  n_first_edges;
    logic [spp_pkg::SECOND_EDGES_W-1:0] r_second_edges, n_second_edges;
    logic                               r_loop,         n_loop;

    logic                               r_s1_valid;
    spp_pkg::t_stage_item               r_s1,           n_s1;
    logic                               r_out_valid;
    spp_pkg::t_out_item                 r_out,          n_out;

    logic                               s2_ready;
    logic                               s1_ready;
    logic                               in_accept;
    logic                               is_first_sensor;
    logic                               is_successor;
    logic [spp_pkg::FIRST_EDGES_W-1:0]  first_edges_inc;
    logic [spp_pkg::SECOND_EDGES_W-1:0] second_edges_inc;
    logic [spp_pkg::COUNT_W-1:0]        period;

    assign s2_ready    = !r_out_valid || o_out.ready;
    assign s1_ready    = !r_s1_valid || s2_ready;
    assign i_in.ready  = s1_ready;
    assign in_accept   = i_in.valid && s1_ready;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    assign is_first_sensor  = (i_in.data.sensor_id == spp_pkg::SENSOR_FIRST);
    assign is_successor     = ({1'b0, i_in.data.sensor_id} == ({1'b0, r_last_sensor} + 9'd1));
    assign first_edges_inc  = r_first_edges + 4'd1;
    assign second_edges_inc = r_second_edges + 6'd1;
    assign period = 32'(i_in.data.timer_value) + ((r_overflow << 16) - r_overflow)
                  - 32'(r_last_timer);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_speed  <= '0;
            r_second_speed <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                spp_pkg::CFG_IDX_FIRST_STAGE_SPEED:  r_first_speed  <= i_cfg_data;
                spp_pkg::CFG_IDX_SECOND_STAGE_SPEED: r_second_speed <= i_cfg_data;
            endcase
        end
    end

    always_comb begin
        n_last_sensor  = r_last_sensor;
        n_last_timer   = r_last_timer;
        n_overflow     = r_overflow;
        n_stage        = r_stage;
        n_first_edges  = r_first_edges;
        n_second_edges = r_second_edges;
        n_loop         = r_loop;
        n_s1           = '0;

        if (i_in.data.operation == spp_pkg::OP_OVERFLOW_TICK) begin
            n_overflow = r_overflow + 32'd1;
        end else if (!i_in.data.maintenance_mode) begin
            if (!r_loop && is_first_sensor) begin
                if (!r_stage) begin
                    n_first_edges = first_edges_inc;
                    if (first_edges_inc >= spp_pkg::FIRST_EDGES_W'(FIRST_STAGE_EDGES)) begin
                        n_first_edges = '0;
                        if (r_second_speed != '0) begin
                            n_stage               = 1'b1;
                            n_s1.start_speed_write = 1'b1;
                            n_s1.start_speed       = r_second_speed;
                        end else begin
                            n_loop = 1'b1;
                        end
                    end
                end else begin
                    n_second_edges = second_edges_inc;
                    if (second_edges_inc >=
                        spp_pkg::SECOND_EDGES_W'(SECOND_STAGE_EDGES)) begin
                        n_stage                = 1'b0;
                        n_second_edges         = '0;
                        n_loop                 = 1'b1;
                        n_s1.start_speed_write = 1'b1;
                        n_s1.start_speed       = r_first_speed;
                    end
                end
            end

            if (is_first_sensor) begin
                n_overflow    = '0;
                n_last_sensor = spp_pkg::SENSOR_FIRST;
                n_last_timer  = i_in.data.timer_value;
            end else if (r_last_sensor != spp_pkg::SENSOR_NONE) begin
                if (is_successor) begin
                    n_overflow        = '0;
                    n_last_sensor     = i_in.data.sensor_id;
                    n_last_timer      = i_in.data.timer_value;
                    n_s1.period_valid = 1'b1;
                    n_s1.period_count = period;
                    n_s1.feed_valid   = r_loop;
                end else begin
                    n_last_sensor = spp_pkg::SENSOR_NONE;
                end
            end
        end

        n_s1.loop_enabled = n_loop;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_sensor  <= spp_pkg::SENSOR_NONE;
            r_last_timer   <= '0;
            r_overflow     <= '0;
            r_stage        <= 1'b0;
            r_first_edges  <= '0;
            r_second_edges <= '0;
            r_loop         <= 1'b0;
        end else if (in_accept) begin
            r_last_sensor  <= n_last_sensor;
            r_last_timer   <= n_last_timer;
            r_overflow     <= n_overflow;
            r_stage        <= n_stage;
            r_first_edges  <= n_first_edges;
            r_second_edges <= n_second_edges;
            r_loop         <= n_loop;
        end
    end

    always_comb begin
        n_out.period_valid       = r_s1.period_valid;
        n_out.period_count       = r_s1.period_count;
        n_out.control_feed_valid = r_s1.feed_valid;
        n_out.control_feed       = r_s1.feed_valid ?
                                   32'(r_s1.period_count * spp_pkg::FEED_FACTOR) : '0;
        n_out.start_speed_write  = r_s1.start_speed_write;
        n_out.start_speed        = r_s1.start_speed;
        n_out.loop_enabled       = r_s1.loop_enabled;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_ready) begin
                r_s1_valid <= i_in.valid;
            end
            if (s2_ready) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1 <= n_s1;
        end
        if (s2_ready && r_s1_valid) begin
            r_out <= n_out;
        end
    end

endmodule

// ===== rtl/spp_checker.sv =====
// Port-level checker for the sensor pair period core and its bind statement.
`include "sensor_pair_period_with_staged_start_core_macros.svh"

module spp_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input spp_pkg::t_out_item i_out_data
);

    `SPP_ASSERT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data), "Stalled result transaction changed or was dropped.")
    `SPP_ASSERT_IMPLIES(a_feed_needs_period, i_clk, i_rst_n, i_out_valid && i_out_data.control_feed_valid, i_out_data.period_valid && i_out_data.loop_enabled, "Controller feed without a period while the loop runs.")
    `SPP_ASSERT_IMPLIES(a_feed_scaled, i_clk, i_rst_n, i_out_valid && i_out_data.control_feed_valid, i_out_data.control_feed == 32'(i_out_data.period_count * spp_pkg::FEED_FACTOR), "Controller feed is not the period scaled by fifty.")
    `SPP_ASSERT_IMPLIES(a_speed_not_period, i_clk, i_rst_n, i_out_valid && i_out_data.start_speed_write, !i_out_data.period_valid, "Start speed write coincides with a period result.")

endmodule

bind sensor_pair_period_with_staged_start_core spp_checker u_spp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  (o_out.data)
);
